// ===== hdl/bzp_pkg.sv =====
package bzp_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned PointW = 34;
  localparam int unsigned StepW  = 6;
  localparam int unsigned ParW   = 17;
  localparam int unsigned WtW    = 51;
  localparam int unsigned AccW   = 84;
  localparam int unsigned FracSh = 48;

  typedef logic signed [PointW-1:0] point_t;

  typedef struct packed {
    point_t [3:0][2:0] pt;
    logic [StepW-1:0]  steps;
  } job_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV,
    B_WT1,
    B_WT2,
    B_MAC,
    B_OUT
  } back_state_t;

endpackage

// ===== hdl/cubic_bezier_path_generator_core.sv =====
// channel   signals                                      dir
// in        in_valid/in_ready, in_way_x/y/z              waypoint in
// out       out_valid/out_ready, out_node_x/y/z, last    node out
// cfg       cfg_we, cfg_wdata (step count)               write only
// a segment start computes the reciprocal of the step count in B_DIV, then each
// node passes the weight states B_WT1 and B_WT2, then B_MAC, which multiplies and
// accumulates over each weight and digit, and then B_OUT, which puts out the node
// waypoints, whether or not they emit a job, are accepted while the job queue has room
// synchronous active-low reset clears history, queue and back-end state
module cubic_bezier_path_generator_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [bzp_pkg::CoordW-1:0] in_way_x,
  input  logic signed [bzp_pkg::CoordW-1:0] in_way_y,
  input  logic signed [bzp_pkg::CoordW-1:0] in_way_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [bzp_pkg::CoordW-1:0] out_node_x,
  output logic signed [bzp_pkg::CoordW-1:0] out_node_y,
  output logic signed [bzp_pkg::CoordW-1:0] out_node_z,
  output logic                              out_last_node,
  input  logic                              cfg_we,
  input  logic [bzp_pkg::StepW-1:0]         cfg_wdata
);

  logic [bzp_pkg::StepW-1:0] step_r;
  logic [bzp_pkg::StepW-1:0] steps;
  logic                      q_push, q_full, q_pop, q_avail;
  bzp_pkg::job_t             push_job, pop_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= bzp_pkg::StepW'(10);
    end else if (cfg_we) begin
      step_r <= cfg_wdata;
    end
  end

  // zero steps behaves as one
  assign steps = (step_r == '0) ? bzp_pkg::StepW'(1) : step_r;

  bzp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_way_x (in_way_x),
    .in_way_y (in_way_y),
    .in_way_z (in_way_z),
    .steps    (steps),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  bzp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .avail    (q_avail),
    .pop_job  (pop_job)
  );

  bzp_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_avail       (q_avail),
    .q_job         (pop_job),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_node_x    (out_node_x),
    .out_node_y    (out_node_y),
    .out_node_z    (out_node_z),
    .out_last_node (out_last_node)
  );

endmodule

// ===== hdl/bzp_front.sv =====
module bzp_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [bzp_pkg::CoordW-1:0] in_way_x,
  input  logic signed [bzp_pkg::CoordW-1:0] in_way_y,
  input  logic signed [bzp_pkg::CoordW-1:0] in_way_z,
  input  logic [bzp_pkg::StepW-1:0]         steps,
  input  logic                              q_full,
  output logic                              q_push,
  output bzp_pkg::job_t                     q_job
);

  logic signed [bzp_pkg::CoordW-1:0] hist_r [3][3];
  logic [2:0]                        idx_r;
  logic [2:0]                        idx_nxt;
  logic                              acc_in;
  logic                              emit;
  logic signed [bzp_pkg::CoordW-1:0] fresh [3];

  assign fresh[0] = in_way_x;
  assign fresh[1] = in_way_y;
  assign fresh[2] = in_way_z;

  assign in_ready = !q_full;
  assign acc_in   = in_valid && in_ready;
  assign emit     = (idx_r == 3'd3) || (idx_r[2] && idx_r[0]);
  assign q_push   = acc_in && emit;

  always_comb begin
    q_job.steps = steps;
    for (int c = 0; c < 3; c++) begin
      if (idx_r == 3'd3) begin
        q_job.pt[0][c] = bzp_pkg::PointW'(hist_r[0][c]);
        q_job.pt[1][c] = bzp_pkg::PointW'(hist_r[1][c]);
      end else begin
        q_job.pt[0][c] = bzp_pkg::PointW'(hist_r[1][c]);
        q_job.pt[1][c] = (bzp_pkg::PointW'(hist_r[1][c]) <<< 1)
                         - bzp_pkg::PointW'(hist_r[0][c]);
      end
      q_job.pt[2][c] = bzp_pkg::PointW'(hist_r[2][c]);
      q_job.pt[3][c] = bzp_pkg::PointW'(fresh[c]);
    end
  end

  always_comb begin
    if (!idx_r[2]) begin
      idx_nxt = idx_r + 3'd1;
    end else begin
      idx_nxt = {2'b10, ~idx_r[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 3'd0;
      for (int k = 0; k < 3; k++) begin
        for (int c = 0; c < 3; c++) begin
          hist_r[k][c] <= '0;
        end
      end
    end else if (acc_in) begin
      idx_r <= idx_nxt;
      for (int c = 0; c < 3; c++) begin
        hist_r[0][c] <= hist_r[1][c];
        hist_r[1][c] <= hist_r[2][c];
        hist_r[2][c] <= fresh[c];
      end
    end
  end

endmodule

// ===== hdl/bzp_queue.sv =====
module bzp_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bzp_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          avail,
  output bzp_pkg::job_t pop_job
);

  bzp_pkg::job_t slot_r [2];
  logic          wr_r;
  logic          rd_r;
  logic [1:0]    cnt_r;

  assign full    = cnt_r == 2'd2;
  assign avail   = cnt_r != 2'd0;
  assign pop_job = slot_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wr_r <= ~wr_r;
      end
      if (pop) begin
        rd_r <= ~rd_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== hdl/bzp_back.sv =====
module bzp_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_avail,
  input  bzp_pkg::job_t                      q_job,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [bzp_pkg::CoordW-1:0]  out_node_x,
  output logic signed [bzp_pkg::CoordW-1:0]  out_node_y,
  output logic signed [bzp_pkg::CoordW-1:0]  out_node_z,
  output logic                               out_last_node
);

  localparam int unsigned PW  = bzp_pkg::ParW;
  localparam int unsigned SW  = bzp_pkg::StepW;
  localparam int unsigned AW  = bzp_pkg::AccW;
  localparam int unsigned WW  = bzp_pkg::WtW;
  localparam int unsigned SQW = 2 * bzp_pkg::ParW;
  localparam int unsigned PRW = bzp_pkg::ParW + bzp_pkg::PointW + 1;

  bzp_pkg::back_state_t state_r, state_nxt;
  bzp_pkg::job_t        job_r;
  logic [PW-1:0]        dvd_r, q_r, t_r;
  logic [SW-1:0]        rem_r, r_r, i_r;
  logic [4:0]           cnt_r;
  logic [2*PW-1:0]      uu_r, tt_r;
  logic [bzp_pkg::WtW-1:0] w_r [4];
  logic signed [AW-1:0] acc_r [3];
  logic [1:0]           j_r, d_r;
  logic                 out_valid_r;
  logic signed [bzp_pkg::CoordW-1:0] node_r [3];
  logic                 last_r;

  logic [PW-1:0]        u;
  logic [SW:0]          div_rs;
  logic                 div_ge;
  logic [SW:0]          stp_rs;
  logic                 stp_cy;
  logic                 out_load;
  logic [PW-1:0]        digit;
  logic [5:0]           shamt;
  logic signed [PW+bzp_pkg::PointW:0] prod [3];
  logic signed [bzp_pkg::CoordW-1:0]  sat [3];
  logic signed [AW-bzp_pkg::FracSh-1:0] top [3];
  logic [3*PW-1:0]      m_ut, m_tu;

  assign u         = PW'(18'h10000 - {1'b0, t_r});
  assign div_rs    = {rem_r, dvd_r[PW-1]};
  assign div_ge    = div_rs >= {1'b0, job_r.steps};
  assign stp_rs    = {1'b0, r_r} + {1'b0, rem_r};
  assign stp_cy    = stp_rs >= {1'b0, job_r.steps};
  assign out_load  = (state_r == bzp_pkg::B_OUT) && (!out_valid_r || out_ready);
  assign q_pop     = (state_r == bzp_pkg::B_IDLE) && q_avail;
  assign m_ut      = WW'(uu_r) * WW'(t_r);
  assign m_tu      = WW'(tt_r) * WW'(u);

  always_comb begin
    unique case (d_r)
      2'd0:    begin digit = w_r[j_r][PW-1:0];        shamt = 6'd0;  end
      2'd1:    begin digit = w_r[j_r][2*PW-1:PW];     shamt = 6'd17; end
      default: begin digit = w_r[j_r][3*PW-1:2*PW];   shamt = 6'd34; end
    endcase
    for (int c = 0; c < 3; c++) begin
      prod[c] = PRW'($signed({1'b0, digit})) * PRW'(job_r.pt[j_r][c]);
      top[c]  = acc_r[c][AW-1:bzp_pkg::FracSh];
      if (top[c][AW-bzp_pkg::FracSh-1:bzp_pkg::CoordW-1] == '0 ||
          top[c][AW-bzp_pkg::FracSh-1:bzp_pkg::CoordW-1] == '1) begin
        sat[c] = top[c][bzp_pkg::CoordW-1:0];
      end else if (top[c][AW-bzp_pkg::FracSh-1]) begin
        sat[c] = {1'b1, {(bzp_pkg::CoordW-1){1'b0}}};
      end else begin
        sat[c] = {1'b0, {(bzp_pkg::CoordW-1){1'b1}}};
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bzp_pkg::B_IDLE: if (q_avail) begin state_nxt = bzp_pkg::B_DIV; end
      bzp_pkg::B_DIV:  if (cnt_r == 5'd16) begin state_nxt = bzp_pkg::B_WT1; end
      bzp_pkg::B_WT1:  state_nxt = bzp_pkg::B_WT2;
      bzp_pkg::B_WT2:  state_nxt = bzp_pkg::B_MAC;
      bzp_pkg::B_MAC:  if (j_r == 2'd3 && d_r == 2'd2) begin state_nxt = bzp_pkg::B_OUT; end
      bzp_pkg::B_OUT: begin
        if (out_load) begin
          state_nxt = (i_r == job_r.steps) ? bzp_pkg::B_IDLE : bzp_pkg::B_WT1;
        end
      end
      default: state_nxt = bzp_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bzp_pkg::B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      bzp_pkg::B_IDLE: begin
        job_r <= q_job;
        dvd_r <= PW'(18'h10000);
        rem_r <= '0;
        cnt_r <= '0;
      end
      bzp_pkg::B_DIV: begin
        rem_r <= div_ge ? SW'(div_rs - {1'b0, job_r.steps}) : div_rs[SW-1:0];
        q_r   <= {q_r[PW-2:0], div_ge};
        dvd_r <= {dvd_r[PW-2:0], 1'b0};
        cnt_r <= cnt_r + 5'd1;
        t_r   <= '0;
        r_r   <= '0;
        i_r   <= '0;
      end
      bzp_pkg::B_WT1: begin
        uu_r <= SQW'(u) * SQW'(u);
        tt_r <= SQW'(t_r) * SQW'(t_r);
      end
      bzp_pkg::B_WT2: begin
        w_r[0] <= WW'(uu_r) * WW'(u);
        w_r[1] <= bzp_pkg::WtW'({m_ut, 1'b0}) + bzp_pkg::WtW'(m_ut);
        w_r[2] <= bzp_pkg::WtW'({m_tu, 1'b0}) + bzp_pkg::WtW'(m_tu);
        w_r[3] <= WW'(tt_r) * WW'(t_r);
        for (int c = 0; c < 3; c++) begin
          acc_r[c] <= '0;
        end
        j_r <= '0;
        d_r <= '0;
      end
      bzp_pkg::B_MAC: begin
        for (int c = 0; c < 3; c++) begin
          acc_r[c] <= acc_r[c] + (AW'(prod[c]) <<< shamt);
        end
        if (d_r == 2'd2) begin
          d_r <= '0;
          j_r <= j_r + 2'd1;
        end else begin
          d_r <= d_r + 2'd1;
        end
      end
      bzp_pkg::B_OUT: begin
        if (out_load) begin
          for (int c = 0; c < 3; c++) begin
            node_r[c] <= sat[c];
          end
          last_r <= i_r == job_r.steps;
          i_r    <= i_r + SW'(1);
          r_r    <= stp_cy ? SW'(stp_rs - {1'b0, job_r.steps}) : stp_rs[SW-1:0];
          t_r    <= t_r + q_r + PW'(stp_cy);
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_node_x    = node_r[0];
  assign out_node_y    = node_r[1];
  assign out_node_z    = node_r[2];
  assign out_last_node = last_r;

endmodule
